>>> design/co2fr_pkg.sv
// ----------------------------------------------------------------------------
// co2fr_pkg
// Shared types and constants for the CO2 sensor frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package co2fr_pkg;

  // Input operation codes (tuser on the slave side)
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Classified item kinds as they travel through the queue
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  // Result status codes (tuser on the master side)
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } qitem_t;

  typedef struct packed {
    status_e           status;
    logic [15:0]       co2_ppm;
    logic signed [8:0] sensor_temp;
  } result_t;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [15:0]       TimeoutResetMs = 16'd1000;
  localparam logic [15:0]       ElapsedMax     = 16'hFFFF;
  localparam logic [3:0]        IdxFirst       = 4'd0;
  localparam logic [3:0]        IdxCo2High     = 4'd2;
  localparam logic [3:0]        IdxCo2Low      = 4'd3;
  localparam logic [3:0]        IdxTemp        = 4'd4;
  localparam logic [3:0]        IdxSumLast     = 4'd7;
  localparam logic [8:0]        TempOffset     = 9'd40;

  // APB register map
  localparam int unsigned ApbAddrW       = 3;
  localparam logic [2:0]  RegTimeoutAddr = 3'h0;

endpackage

`default_nettype wire

>>> design/co2_sensor_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// co2_sensor_frame_receiver_core
// Receiver for the 9-byte response frame of an NDIR CO2 sensor.
// ----------------------------------------------------------------------------
// A start transaction arms the receiver and clears byte count, sum and elapsed
// time. While armed, byte transactions build the frame: bytes 1..7 are summed
// mod 256, the ninth byte must equal the two's complement of that sum, and the
// ninth byte produces one result: ok with CO2 ppm (byte2:byte3) and
// temperature (byte4 - 40), or checksum error with zero fields. Millisecond
// tick transactions count up (saturating at 65535); the tick that reaches
// timeout_ms yields a timeout result with zero fields. Bytes and ticks while
// disarmed, and operation code 3, are dropped. The block takes one transaction
// per clock while the queue is not full: a classifier feeds a two-entry queue,
// and the frame engine retires one queued item per cycle into a one-deep
// result register while that register is free or draining, so input and
// output stall independently. A transaction that yields a result passes the
// queue, then the result register, before result valid rises. timeout_ms sits
// at APB byte address 0 (reset 1000); write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_sensor_frame_receiver_core #(
  parameter int unsigned QueueDepth = co2fr_pkg::QueueDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  wire logic [1:0]                    s_axis_tuser,  // [1:0] operation
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // [15:0] co2_ppm,
                                                            // [24:16] sensor_temp
  output logic [1:0]                         m_axis_tuser,  // [1:0] status
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [co2fr_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import co2fr_pkg::*;

  logic [15:0] timeout_ms_q;
  logic        apb_wr;

  qitem_t      front_item;
  logic        front_keep;
  logic        q_full;
  qitem_t      q_head;
  logic        q_valid;
  logic        q_pop;
  result_t     res;

  // ---- configuration ----
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ms_q <= TimeoutResetMs;
    end else if (apb_wr && paddr == RegTimeoutAddr) begin
      timeout_ms_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr == RegTimeoutAddr) ? {16'h0000, timeout_ms_q} : 32'h0000_0000;

  // ---- front: classify ----
  co2fr_front u_front (
    .op_i      (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .item_o    (front_item),
    .keep_o    (front_keep)
  );

  // dropped codes are accepted without using a queue slot
  assign s_axis_tready = !q_full;

  co2fr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid && front_keep),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .valid_o     (q_valid)
  );

  // ---- back: frame engine ----
  co2fr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timeout_ms_i (timeout_ms_q),
    .item_i       (q_head),
    .item_valid_i (q_valid),
    .item_pop_o   (q_pop),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {7'b0000000, res.sensor_temp, res.co2_ppm};
  assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

>>> design/co2fr_front.sv
// ----------------------------------------------------------------------------
// co2fr_front
// Input classifier: decodes the operation code and drops meaningless items.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_front (
  input  wire logic [1:0]      op_i,
  input  wire logic [7:0]      rx_byte_i,
  output co2fr_pkg::qitem_t    item_o,
  output logic                 keep_o
);
  import co2fr_pkg::*;

  always_comb begin
    item_o = '{kind: KIND_START, data: 8'h00};
    keep_o = 1'b1;
    case (op_i)
      OP_START: item_o.kind = KIND_START;
      OP_BYTE: begin
        item_o.kind = KIND_BYTE;
        item_o.data = rx_byte_i;
      end
      OP_TICK:  item_o.kind = KIND_TICK;
      default:  keep_o = 1'b0; // undefined op: accepted, then dropped
    endcase
  end

endmodule

`default_nettype wire

>>> design/co2fr_queue.sv
// ----------------------------------------------------------------------------
// co2fr_queue
// Small FIFO between front and back; show-ahead read.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_queue #(
  parameter int unsigned Depth = co2fr_pkg::QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  co2fr_pkg::qitem_t       push_item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output co2fr_pkg::qitem_t       head_o,
  output logic                    valid_o
);
  import co2fr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  qitem_t           mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> design/co2fr_back.sv
// ----------------------------------------------------------------------------
// co2fr_back
// Frame state machine: byte count, checksum, timeout; registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [15:0]     timeout_ms_i,
  input  co2fr_pkg::qitem_t    item_i,
  input  wire logic            item_valid_i,
  output logic                 item_pop_o,
  output co2fr_pkg::result_t   res_o,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i
);
  import co2fr_pkg::*;

  logic        armed_q, armed_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  co2_high_q, co2_low_q, temp_raw_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic        emit;
  result_t     emit_res;
  logic [15:0] elapsed_inc;
  logic [7:0]  expect_sum;

  // take a queued item whenever the result slot is free or draining
  assign item_pop_o  = item_valid_i && (!out_valid_q || res_ready_i);
  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 16'd1;
  assign expect_sum  = ~sum_q + 8'd1;

  always_comb begin
    armed_d   = armed_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    elapsed_d = elapsed_q;
    emit      = 1'b0;
    emit_res  = '{status: ST_OK, co2_ppm: 16'h0000, sensor_temp: 9'sd0};
    if (item_pop_o) begin
      case (item_i.kind)
        KIND_START: begin
          armed_d   = 1'b1;
          idx_d     = IdxFirst;
          sum_d     = 8'h00;
          elapsed_d = 16'h0000;
        end
        KIND_BYTE: begin
          if (armed_q) begin
            if (idx_q == IdxFirst) begin
              idx_d = idx_q + 4'd1;
            end else if (idx_q <= IdxSumLast) begin
              idx_d = idx_q + 4'd1;
              sum_d = sum_q + item_i.data;
            end else begin
              // ninth byte: checksum
              armed_d = 1'b0;
              idx_d   = IdxFirst;
              emit    = 1'b1;
              if (item_i.data != expect_sum) begin
                emit_res.status = ST_CHECKSUM;
              end else begin
                emit_res.co2_ppm     = {co2_high_q, co2_low_q};
                emit_res.sensor_temp = $signed({1'b0, temp_raw_q} - TempOffset);
              end
            end
          end
        end
        KIND_TICK: begin
          if (armed_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_ms_i) begin
              armed_d         = 1'b0;
              idx_d           = IdxFirst;
              emit            = 1'b1;
              emit_res.status = ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      idx_q       <= IdxFirst;
      sum_q       <= 8'h00;
      elapsed_q   <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: frame fields and result register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (item_pop_o && armed_q && item_i.kind == KIND_BYTE) begin
      if (idx_q == IdxCo2High) co2_high_q <= item_i.data;
      if (idx_q == IdxCo2Low)  co2_low_q  <= item_i.data;
      if (idx_q == IdxTemp)    temp_raw_q <= item_i.data;
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> design/co2fr_checker.sv
// ----------------------------------------------------------------------------
// co2fr_checker
// Port-level checks for the CO2 frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);
  import co2fr_pkg::*;

  // stalled result holds
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // failure results carry zero measurement fields
  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_TIMEOUT |-> m_axis_tdata == 32'h0)
    else $error("timeout result with nonzero data");

  a_cksum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_CHECKSUM |-> m_axis_tdata == 32'h0)
    else $error("checksum result with nonzero data");

  // timeout register read-back after a write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr == RegTimeoutAddr) ##1 (paddr == RegTimeoutAddr)
      |-> prdata == {16'h0000, $past(pwdata[15:0])})
    else $error("timeout register read-back mismatch");

endmodule

bind co2_sensor_frame_receiver_core co2fr_checker u_co2fr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire
